>>> rtl/core/tks_pkg.sv
// Package for the top-k sum tracker: shared constants, codes and the
// command and status structs between controller and datapath. No dependencies.
package tks_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam int VALUE_W_DEF  = 32;
  localparam int VALUE_IN_W   = 32;
  localparam int SUM_W        = 38;
  localparam int K_W          = 7;
  localparam int ADDR_W       = 3;
  localparam int DATA_W       = 32;

  // Request commands.
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_ERASE  = 1'b1;

  // Register index of k.
  localparam logic REG_TOP_COUNT = 1'b0;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROT,
    ST_DONE
  } tks_state_e;

  typedef struct packed {
    logic apply;
    logic rotate;
    logic load_out;
  } tks_cmd_t;

  typedef struct packed {
    logic rot_last;
  } tks_stat_t;

endpackage

>>> rtl/core/top_k_sum_tracker.sv
// Top level of the top-k sum tracker: configuration port, controller and
// datapath. Depends on tks_pkg, tks_ctrl and tks_dp.
//
// Usage: requests arrive on the input channel (command_i, value_i) with
// in_valid_i and in_stall_o; a request inserts a value or erases one copy.
// One result per request leaves on the output channel (ok_o, top_sum_o,
// sum_valid_o, element_count_o) with out_valid_o and out_stall_i.
// A request applies its compare and shift to the sorted cells in the cycle
// it is accepted, then the row rotates once through all CAPACITY cells to
// sum the largest k; the result is then loaded into the output registers.
// A new request is taken only after the previous one has finished its
// rotation pass over the cell row and its result has been loaded.
// A result waiting under out_stall_i does not block acceptance of the next
// request; that request then holds in its final cycle until the output
// register is free. k is written through the APB port at address 0 and
// should change only while the block is idle. Reset empties the store,
// sets k to 1 and drops any pending result.
module top_k_sum_tracker #(
  parameter int CAPACITY = tks_pkg::CAPACITY_DEF,
  parameter int VALUE_W  = tks_pkg::VALUE_W_DEF,
  parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [tks_pkg::ADDR_W-1:0]        paddr,
  input  logic [tks_pkg::DATA_W-1:0]        pwdata,
  output logic [tks_pkg::DATA_W-1:0]        prdata,
  output logic                              pready,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              command_i,
  input  logic [tks_pkg::VALUE_IN_W-1:0]    value_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              ok_o,
  output logic signed [tks_pkg::SUM_W-1:0]  top_sum_o,
  output logic                              sum_valid_o,
  output logic [CNT_W-1:0]                  element_count_o
);
  import tks_pkg::*;

  logic [K_W-1:0] top_count_q;
  tks_cmd_t       cmd;
  tks_stat_t      stat;

  assign pready = 1'b1;

  // k register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_count_q <= K_W'(1);
    end else if (psel && penable && pwrite && paddr[2] == REG_TOP_COUNT) begin
      top_count_q <= pwdata[K_W-1:0];
    end
  end

  // Register read back.
  assign prdata = (paddr[2] == REG_TOP_COUNT) ? DATA_W'(top_count_q) : '0;

  tks_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  tks_dp #(
    .CAPACITY (CAPACITY),
    .VALUE_W  (VALUE_W),
    .CNT_W    (CNT_W)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .command_i       (command_i),
    .value_i         (value_i),
    .top_count_i     (top_count_q),
    .ok_o            (ok_o),
    .top_sum_o       (top_sum_o),
    .sum_valid_o     (sum_valid_o),
    .element_count_o (element_count_o)
  );

endmodule

>>> rtl/core/tks_ctrl.sv
// Controller of the top-k sum tracker: accepts requests, steps the datapath
// through its rotation pass and hands results to the output. Uses tks_pkg.
module tks_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output tks_pkg::tks_cmd_t cmd_o,
  input  tks_pkg::tks_stat_t stat_i
);
  import tks_pkg::*;

  tks_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;

  // State and output-valid registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.apply = 1'b1;
          state_d     = ST_ROT;
        end
      end
      ST_ROT: begin
        cmd_o.rotate = 1'b1;
        if (stat_i.rot_last) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

>>> rtl/core/tks_dp.sv
// Datapath of the top-k sum tracker: the sorted row of cells with parallel
// compare and shift, the rotation pass that sums the top k, and result
// registers. Uses tks_pkg.
module tks_dp #(
  parameter int CAPACITY = tks_pkg::CAPACITY_DEF,
  parameter int VALUE_W  = tks_pkg::VALUE_W_DEF,
  parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  tks_pkg::tks_cmd_t            cmd_i,
  output tks_pkg::tks_stat_t           stat_o,
  input  logic                         command_i,
  input  logic [tks_pkg::VALUE_IN_W-1:0] value_i,
  input  logic [tks_pkg::K_W-1:0]      top_count_i,
  output logic                         ok_o,
  output logic signed [tks_pkg::SUM_W-1:0] top_sum_o,
  output logic                         sum_valid_o,
  output logic [CNT_W-1:0]             element_count_o
);
  import tks_pkg::*;

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CMP_W = ((CNT_W > K_W) ? CNT_W : K_W) + 1;

  logic signed [VALUE_W-1:0] cell_q [CAPACITY];
  logic signed [VALUE_W-1:0] cell_d [CAPACITY];
  logic [CNT_W-1:0]          count_q, count_d;
  logic [IDX_W-1:0]          rot_q;
  logic signed [SUM_W-1:0]   acc_q;
  logic                      ok_q, ok_d;
  logic [63:0]               value_ext;
  logic signed [VALUE_W-1:0] vin;
  logic [CAPACITY-1:0]       big, ge, eq;
  logic                      found, full;
  logic [CMP_W-1:0]          rank_gap, k_ext;
  logic                      add_en;

  // Incoming value, low VALUE_W bits of the zero-extended port.
  assign value_ext = {{(64 - VALUE_IN_W){1'b0}}, value_i};
  assign vin       = value_ext[VALUE_W-1:0];

  // Per-cell compares against the request value.
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      big[i] = (CNT_W'(i) < count_q) && (cell_q[i] > vin);
      ge[i]  = (CNT_W'(i) < count_q) && (cell_q[i] >= vin);
      eq[i]  = (CNT_W'(i) < count_q) && (cell_q[i] == vin);
    end
  end

  assign found = |eq;
  assign full  = (count_q == CNT_W'(CAPACITY));

  // Next contents of the cells: insert, erase or rotate by one.
  always_comb begin
    count_d = count_q;
    ok_d    = ok_q;
    for (int i = 0; i < CAPACITY; i++) begin
      cell_d[i] = cell_q[i];
    end
    if (cmd_i.apply) begin
      if (command_i == CMD_INSERT) begin
        ok_d = !full;
        if (!full) begin
          count_d = count_q + CNT_W'(1);
          for (int i = 0; i < CAPACITY; i++) begin
            if (i > 0 && big[(i > 0) ? i - 1 : 0]) begin
              cell_d[i] = cell_q[(i > 0) ? i - 1 : 0];
            end else if (big[i] || CNT_W'(i) == count_q) begin
              cell_d[i] = vin;
            end
          end
        end
      end else begin
        ok_d = found;
        if (found) begin
          count_d = count_q - CNT_W'(1);
          for (int i = 0; i < CAPACITY - 1; i++) begin
            if (ge[i]) begin
              cell_d[i] = cell_q[i + 1];
            end
          end
        end
      end
    end else if (cmd_i.rotate) begin
      for (int i = 0; i < CAPACITY; i++) begin
        cell_d[i] = cell_q[(i + 1) % CAPACITY];
      end
    end
  end

  // The cell now at the head is rank rot_q; add it when among the top k.
  assign rank_gap = CMP_W'(count_q) - CMP_W'(1) - CMP_W'(rot_q);
  assign k_ext    = CMP_W'(top_count_i);
  assign add_en   = (CMP_W'(rot_q) < CMP_W'(count_q)) && (rank_gap < k_ext);
  assign stat_o.rot_last = (rot_q == IDX_W'(CAPACITY - 1));

  // Cell row, payload only.
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < CAPACITY; i++) begin
      cell_q[i] <= cell_d[i];
    end
  end

  // Count, rotation index, accumulator and status.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      rot_q   <= '0;
      acc_q   <= '0;
      ok_q    <= 1'b0;
    end else begin
      count_q <= count_d;
      ok_q    <= ok_d;
      if (cmd_i.apply) begin
        rot_q <= '0;
        acc_q <= '0;
      end else if (cmd_i.rotate) begin
        rot_q <= rot_q + IDX_W'(1);
        if (add_en) begin
          acc_q <= acc_q + SUM_W'(cell_q[0]);
        end
      end
    end
  end

  // Result registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      ok_o            <= ok_q;
      top_sum_o       <= acc_q;
      sum_valid_o     <= CMP_W'(count_q) >= k_ext;
      element_count_o <= count_q;
    end
  end

endmodule

>>> sim/tb.sv
// Testbench for the top-k sum tracker: drives insert and erase requests,
// writes k over the APB port and checks every result against a local model.
// Depends on tks_pkg and top_k_sum_tracker.
`timescale 1ns / 100ps

module tb;
  import tks_pkg::*;

  localparam int CAP       = 64;
  localparam int CNT_W     = 7;
  localparam int WATCH_MAX = 20000;
  localparam int SETTLE    = CAP + 10;

  typedef struct {
    logic                    ok;
    logic signed [SUM_W-1:0] top_sum;
    logic                    sum_valid;
    logic [CNT_W-1:0]        count;
  } result_t;

  typedef struct {
    logic        cmd;
    logic [31:0] val;
    logic        has_exp;
    logic        e_ok;
    logic [6:0]  e_count;
  } step_t;

  logic clk_i, rst_ni;
  logic psel, penable, pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata, prdata;
  logic pready;
  logic in_valid_i, in_stall_o, command_i;
  logic [VALUE_IN_W-1:0] value_i;
  logic out_valid_o, out_stall_i, ok_o, sum_valid_o;
  logic signed [SUM_W-1:0] top_sum_o;
  logic [CNT_W-1:0] element_count_o;

  top_k_sum_tracker dut (.*);

  // Local model of the sorted multiset and k.
  logic signed [31:0] held_vals[$];
  int unsigned        k_val;
  result_t            pending_results[$];
  int                 fail_count;
  int                 idle_cycles;
  int                 send_idle_pct, recv_idle_pct;

  function automatic result_t apply_request(logic cmd, logic signed [31:0] v);
    result_t r;
    int pos, m;
    logic signed [SUM_W-1:0] acc;
    r.ok = 1'b0;
    if (cmd == CMD_INSERT) begin
      if (held_vals.size() < CAP) begin
        pos = 0;
        while (pos < held_vals.size() && held_vals[pos] <= v) pos++;
        held_vals.insert(pos, v);
        r.ok = 1'b1;
      end
    end else begin
      for (int i = 0; i < held_vals.size(); i++) begin
        if (held_vals[i] == v) begin
          held_vals.delete(i);
          r.ok = 1'b1;
          break;
        end
      end
    end
    m = (k_val < held_vals.size()) ? k_val : held_vals.size();
    acc = '0;
    for (int i = held_vals.size() - m; i < held_vals.size(); i++)
      acc += SUM_W'(held_vals[i]);
    r.top_sum   = acc;
    r.sum_valid = (held_vals.size() >= k_val);
    r.count     = CNT_W'(held_vals.size());
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch on %s: got %0d, expected %0d", what, got, want);
    fail_count++;
  endtask

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Result checking and receiver stalls.
  always @(posedge clk_i) begin
    result_t e;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected result", 1, 0);
        end else begin
          e = pending_results.pop_front();
          if (ok_o !== e.ok) report_mismatch("ok", ok_o, e.ok);
          if (top_sum_o !== e.top_sum) report_mismatch("top_sum", top_sum_o, e.top_sum);
          if (sum_valid_o !== e.sum_valid)
            report_mismatch("sum_valid", sum_valid_o, e.sum_valid);
          if (element_count_o !== e.count)
            report_mismatch("element_count", element_count_o, e.count);
        end
      end
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Watchdog on cycles with no accepted request or result.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCH_MAX) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic write_k(int unsigned k);
    @(posedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= ADDR_W'(4 * REG_TOP_COUNT); pwdata <= k;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    k_val = k & 32'h7F;
  endtask

  // Sends one request and records its expected result. Valid stays high
  // after acceptance so that a following request can be presented at once.
  task automatic send_request(logic cmd, logic [31:0] v, output result_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1; command_i <= cmd; value_i <= v;
    do @(posedge clk_i); while (in_stall_o);
    r = apply_request(cmd, v);
    pending_results.push_back(r);
  endtask

  task automatic drain;
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // Random phase: mostly erases of held values and inserts, some misses.
  task automatic random_phase(int n);
    result_t r;
    logic [31:0] v;
    logic cmd;
    int sel;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(99);
      cmd = (sel < 50) ? CMD_INSERT : CMD_ERASE;
      if (cmd == CMD_ERASE && held_vals.size() != 0 && sel < 88)
        v = held_vals[$urandom_range(held_vals.size() - 1)];
      else if ($urandom_range(3) == 0 && held_vals.size() != 0)
        v = held_vals[$urandom_range(held_vals.size() - 1)];
      else if ($urandom_range(3) == 0)
        v = $urandom_range(15) - 8;
      else
        v = $urandom;
      send_request(cmd, v, r);
    end
  endtask

  // Directed table: extremes, duplicates and misses.
  step_t directed[10] = '{
    '{CMD_ERASE,  32'h0000_0005, 1'b1, 1'b0, 7'd0},
    '{CMD_INSERT, 32'h7FFF_FFFF, 1'b1, 1'b1, 7'd1},
    '{CMD_INSERT, 32'h8000_0000, 1'b1, 1'b1, 7'd2},
    '{CMD_INSERT, 32'h7FFF_FFFF, 1'b1, 1'b1, 7'd3},
    '{CMD_ERASE,  32'h7FFF_FFFF, 1'b1, 1'b1, 7'd2},
    '{CMD_ERASE,  32'h0000_0000, 1'b1, 1'b0, 7'd2},
    '{CMD_INSERT, 32'hFFFF_FFFF, 1'b0, 1'b0, 7'd0},
    '{CMD_INSERT, 32'h0000_0000, 1'b0, 1'b0, 7'd0},
    '{CMD_ERASE,  32'h8000_0000, 1'b0, 1'b0, 7'd0},
    '{CMD_ERASE,  32'h8000_0000, 1'b1, 1'b0, 7'd3}
  };

  initial begin
    result_t r;
    psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    in_valid_i = 0; command_i = 0; value_i = '0; out_stall_i = 0;
    fail_count = 0; idle_cycles = 0; k_val = 1;
    send_idle_pct = 0; recv_idle_pct = 0;
    rst_ni = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed[i]) begin
      send_request(directed[i].cmd, directed[i].val, r);
      if (directed[i].has_exp) begin
        if (r.ok !== directed[i].e_ok) report_mismatch("table ok", r.ok, directed[i].e_ok);
        if (r.count !== directed[i].e_count)
          report_mismatch("table count", r.count, directed[i].e_count);
      end
    end
    drain();

    // Fill the store with large values, then one insert beyond capacity.
    write_k(64);
    while (held_vals.size() < CAP) send_request(CMD_INSERT, 32'h7FFF_FFFF, r);
    send_request(CMD_INSERT, 32'h8000_0000, r);
    if (r.ok !== 1'b0) report_mismatch("full store ok", r.ok, 0);
    drain();
    write_k(0);
    send_request(CMD_ERASE, 32'h7FFF_FFFF, r);
    drain();
    write_k(127);
    send_request(CMD_ERASE, 32'h7FFF_FFFF, r);
    while (held_vals.size() > 0) send_request(CMD_ERASE, held_vals[0], r);
    drain();

    // Random part in three idling regimes, with varied k between them.
    send_idle_pct = 27; recv_idle_pct = 58;
    write_k(3);
    random_phase(250);
    drain();
    write_k($urandom_range(64));
    random_phase(220);
    drain();
    send_idle_pct = 58; recv_idle_pct = 27;
    write_k(1);
    random_phase(230);
    drain();
    write_k(64);
    random_phase(220);
    drain();
    send_idle_pct = 0; recv_idle_pct = 0;
    write_k(0);
    random_phase(220);
    drain();
    write_k($urandom_range(127));
    random_phase(220);
    drain();

    if (fail_count == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
